/* sv/lldc_pkg.sv */
// shared types and constants for the log-law drag coefficient block
`default_nettype none
package lldc_pkg;

    localparam int LN_LAT  = 26;   // normalize, 24 squaring steps, ln2 scale
    localparam int DIV_LAT = 33;   // setup plus one quotient bit per stage
    localparam logic [31:0] LN2_Q32  = 32'd2977044472;
    localparam logic [31:0] DRAG_MAX = 32'hFFFF_FFFF;
    localparam logic [15:0] KARMAN_RESET = 16'd26214;
    localparam logic [31:0] ROUGH_RESET  = 32'd66;

    typedef enum logic [1:0] {
        CLS_DRY     = 2'd0,
        CLS_VISCOUS = 2'd1,
        CLS_ROUGH   = 2'd2
    } node_class_t;

    typedef enum logic {
        REG_KARMAN = 1'b0,
        REG_ROUGH  = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [31:0] h;
        logic [31:0] z;
        logic [31:0] floor_v;
        logic        last;
        node_class_t cls;
        logic        dry;
    } side_t;

endpackage
`default_nettype wire

/* sv/lldc_ln.sv */
// pipelined natural log of a 32-bit integer, unsigned q.24 result
`default_nettype none
module lldc_ln (
    input  wire logic                      clk,
    input  wire logic [lldc_pkg::LN_LAT-1:0] en,
    input  wire logic [31:0]               x,
    output logic [28:0]                    ln
);
    import lldc_pkg::*;

    localparam int NSQ = LN_LAT - 2;

    logic [31:0] m_reg  [NSQ+1];
    logic [28:0] lg_reg [NSQ+1];
    logic [28:0] ln_reg;
    logic [31:0] xx;
    logic [4:0]  e;
    logic [63:0] p [NSQ];
    logic [60:0] scaled;

    // msb position and left alignment
    always_comb
    begin
        xx = (x == 32'd0) ? 32'd1 : x;
        e  = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (xx[i])
            begin
                e = 5'(i);
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < NSQ; j++)
        begin
            p[j] = 64'(m_reg[j]) * 64'(m_reg[j]);
        end
        scaled = 61'(61'(lg_reg[NSQ]) * 61'(LN2_Q32));
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            m_reg[0]  <= xx << (5'd31 - e);
            lg_reg[0] <= {e, 24'd0};
        end
        for (int j = 0; j < NSQ; j++)
        begin
            if (en[j+1])
            begin
                // square in q1.31, renormalize when it reaches two
                if (p[j][63])
                begin
                    m_reg[j+1]  <= p[j][63:32];
                    lg_reg[j+1] <= lg_reg[j] | (29'd1 << (NSQ - 1 - j));
                end
                else
                begin
                    m_reg[j+1]  <= p[j][62:31];
                    lg_reg[j+1] <= lg_reg[j];
                end
            end
        end
        if (en[LN_LAT-1])
        begin
            ln_reg <= scaled[60:32];
        end
    end

    assign ln = ln_reg;

endmodule
`default_nettype wire

/* sv/lldc_div.sv */
// pipelined restoring divider, floor(nm * 2^32 / dm) with overflow flag
`default_nettype none
module lldc_div (
    input  wire logic                        clk,
    input  wire logic [lldc_pkg::DIV_LAT-1:0] en,
    input  wire logic [47:0]                 nm,
    input  wire logic [62:0]                 dm,
    output logic [31:0]                      q,
    output logic                             sat
);
    import lldc_pkg::*;

    localparam int NB = DIV_LAT - 1;

    logic [62:0] r_reg   [NB+1];
    logic [62:0] d_reg   [NB+1];
    logic [31:0] q_reg   [NB+1];
    logic        sat_reg [NB+1];
    logic [63:0] r2   [NB];
    logic [63:0] diff [NB];
    logic        ge   [NB];

    always_comb
    begin
        for (int j = 0; j < NB; j++)
        begin
            r2[j]   = {r_reg[j], 1'b0};
            diff[j] = r2[j] - {1'b0, d_reg[j]};
            ge[j]   = r2[j] >= {1'b0, d_reg[j]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            r_reg[0]   <= {15'd0, nm};
            d_reg[0]   <= dm;
            q_reg[0]   <= 32'd0;
            // quotient reaches 2^32 exactly when nm >= dm, zero divisor included
            sat_reg[0] <= {15'd0, nm} >= dm;
        end
        for (int j = 0; j < NB; j++)
        begin
            if (en[j+1])
            begin
                r_reg[j+1]   <= ge[j] ? diff[j][62:0] : r2[j][62:0];
                d_reg[j+1]   <= d_reg[j];
                q_reg[j+1]   <= {q_reg[j][30:0], ge[j]};
                sat_reg[j+1] <= sat_reg[j];
            end
        end
    end

    assign q   = q_reg[NB];
    assign sat = sat_reg[NB];

endmodule
`default_nettype wire

/* sv/log_law_drag_coefficient.sv */
// top level of the log-law bottom drag coefficient pipeline
// One mesh node per transfer: depth, roughness and floor go in, a Q8.24 drag
// coefficient and a friction class come out. The datapath is a 66-stage
// pipeline (input register, 26-stage log unit for depth and roughness in
// parallel, 4 stages of products and magnitudes, a 33-stage divider with one
// quotient bit per stage, square and clamp), and a new node is taken every
// cycle while no stall holds it. Each stage advances when it is empty or its
// successor moves, so bubbles collapse and a stall on the output side fills
// the pipeline before in_ready drops.
// Registers: karman_const at address 0, default_rough_len at address 4.
`default_nettype none
module log_law_drag_coefficient (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // node input
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] depth,
    input  wire logic [31:0] rough_len,
    input  wire logic [31:0] min_drag,
    input  wire logic        last_node,
    // result output
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      drag,
    output logic [1:0]       node_class,
    output logic             last_out
);
    import lldc_pkg::*;

    // stage numbering
    localparam int ST_LN  = 1;                   // first log stage
    localparam int ST_LR  = ST_LN + LN_LAT;      // log difference
    localparam int ST_MUL = ST_LR + 1;           // products
    localparam int ST_DEN = ST_MUL + 1;          // denominator sum
    localparam int ST_ABS = ST_DEN + 1;          // magnitude
    localparam int ST_DIV = ST_ABS + 1;          // first divider stage
    localparam int ST_SQ  = ST_DIV + DIV_LAT;    // square
    localparam int NST    = ST_SQ + 2;           // output stage is NST-1

    // register file
    logic [15:0] karman_reg;
    logic [31:0] rough_reg;
    reg_idx_t    widx;
    logic        wr_en;

    assign pready = 1'b1;
    assign widx   = reg_idx_t'(paddr[2]);
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            karman_reg <= KARMAN_RESET;
            rough_reg  <= ROUGH_RESET;
        end
        else if (wr_en)
        begin
            case (widx)
                REG_KARMAN: karman_reg <= pwdata[15:0];
                REG_ROUGH:  rough_reg  <= pwdata;
                default:    rough_reg  <= rough_reg;
            endcase
        end
    end

    always_comb
    begin
        case (widx)
            REG_KARMAN: prdata = {16'd0, karman_reg};
            REG_ROUGH:  prdata = rough_reg;
            default:    prdata = 32'd0;
        endcase
    end

    // stage valids and per-stage advance
    logic [NST-1:0] v_reg;
    logic [NST-1:0] en;

    always_comb
    begin
        en[NST-1] = !v_reg[NST-1] || out_ready;
        for (int i = NST - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NST-1];

    // node classification at entry
    side_t side_in;
    side_t side_reg [NST];

    always_comb
    begin
        side_in.h       = depth;
        side_in.floor_v = min_drag;
        side_in.last    = last_node;
        side_in.dry     = rough_len >= depth;
        if (rough_len == 32'd0)
        begin
            // viscous node takes the default roughness, zero read as one lsb
            side_in.cls = CLS_VISCOUS;
            side_in.z   = (rough_reg == 32'd0) ? 32'd1 : rough_reg;
        end
        else
        begin
            side_in.cls = CLS_ROUGH;
            side_in.z   = rough_len;
        end
        if (side_in.dry)
        begin
            side_in.cls = CLS_DRY;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            side_reg[0] <= side_in;
        end
        for (int i = 1; i < NST; i++)
        begin
            if (en[i])
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // ln of depth and roughness, in parallel
    logic [28:0] ln_h;
    logic [28:0] ln_z;

    lldc_ln u_ln_h (
        .clk (clk),
        .en  (en[ST_LR-1:ST_LN]),
        .x   (side_reg[0].h),
        .ln  (ln_h)
    );

    lldc_ln u_ln_z (
        .clk (clk),
        .en  (en[ST_LR-1:ST_LN]),
        .x   (side_reg[0].z),
        .ln  (ln_z)
    );

    // numerator k(H - z0), denominator H ln(H/z0) + (z0 - H) 2^24
    logic signed [29:0] lr_reg;
    logic signed [32:0] hz_reg;
    logic signed [62:0] prod_reg;
    logic signed [49:0] numv_reg;
    logic signed [32:0] hz2_reg;
    logic signed [63:0] den_reg;
    logic [47:0]        nm_reg;
    logic [62:0]        dm_reg;
    logic [47:0]        nm2_reg;
    logic signed [63:0] den_next;
    logic signed [49:0] nabs;
    logic signed [63:0] dabs;

    always_comb
    begin
        den_next = 64'(prod_reg) - (64'(hz2_reg) <<< 24);
        nabs     = (numv_reg < 0) ? -numv_reg : numv_reg;
        dabs     = (den_reg < 0) ? -den_reg : den_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_LR])
        begin
            lr_reg <= $signed({1'b0, ln_h}) - $signed({1'b0, ln_z});
            hz_reg <= $signed({1'b0, side_reg[ST_LR-1].h}) - $signed({1'b0, side_reg[ST_LR-1].z});
        end
        if (en[ST_MUL])
        begin
            prod_reg <= 63'($signed({1'b0, side_reg[ST_MUL-1].h}) * lr_reg);
            numv_reg <= 50'($signed({1'b0, karman_reg}) * hz_reg);
            hz2_reg  <= hz_reg;
        end
        if (en[ST_DEN])
        begin
            den_reg <= den_next;
            nm_reg  <= nabs[47:0];
        end
        if (en[ST_ABS])
        begin
            dm_reg  <= dabs[62:0];
            nm2_reg <= nm_reg;
        end
    end

    // |ratio| in q.24
    logic [31:0] t_q;
    logic        t_sat;

    lldc_div u_div (
        .clk (clk),
        .en  (en[ST_SQ-1:ST_DIV]),
        .nm  (nm2_reg),
        .dm  (dm_reg),
        .q   (t_q),
        .sat (t_sat)
    );

    // square, saturate, floor
    logic [63:0] sq_reg;
    logic        sat_reg;
    logic [31:0] drag_reg;
    logic [31:0] drag_next;

    always_comb
    begin
        if (side_reg[NST-2].dry)
        begin
            drag_next = 32'd0;
        end
        else if (sat_reg || (sq_reg[63:56] != 8'd0))
        begin
            drag_next = DRAG_MAX;
        end
        else if (sq_reg[55:24] < side_reg[NST-2].floor_v)
        begin
            drag_next = side_reg[NST-2].floor_v;
        end
        else
        begin
            drag_next = sq_reg[55:24];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_SQ])
        begin
            sq_reg  <= 64'(t_q) * 64'(t_q);
            sat_reg <= t_sat;
        end
        if (en[NST-1])
        begin
            drag_reg <= drag_next;
        end
    end

    assign drag       = drag_reg;
    assign node_class = side_reg[NST-1].cls;
    assign last_out   = side_reg[NST-1].last;

    // a dry node never reports drag
    a_dry_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (node_class == CLS_DRY) |-> drag == 32'd0)
        else $error("dry node with nonzero drag");

    // an empty entry stage always takes a transfer
    a_entry_open: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[0] |-> in_ready)
        else $error("entry stage empty but input stalled");

    // a stalled result stays in the output stage
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped under stall");

endmodule
`default_nettype wire

/* test/lldc_checker.sv */
// checker: watches node and result transfers, predicts drag and compares
`timescale 1ns / 100ps
module lldc_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [31:0] depth,
    input  wire logic [31:0] rough_len,
    input  wire logic [31:0] min_drag,
    input  wire logic        last_node,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [31:0] drag,
    input  wire logic [1:0]  node_class,
    input  wire logic        last_out,
    output int               fail_count,
    output int               pending
);
    import lldc_pkg::*;

    typedef struct packed {
        logic [31:0] drag;
        node_class_t cls;
        logic        last;
    } drag_result_t;

    drag_result_t expected_drag_q[$];
    logic [15:0]  karman;
    logic [31:0]  rough_default;

    assign pending = expected_drag_q.size();

    // natural log of a raw 32-bit value, Q.24
    function automatic longint log_q24(logic [31:0] x);
        int          e;
        logic [63:0] m;
        logic [63:0] lg;
        logic [95:0] prod;
        e = 31;
        if (x == 0)
            x = 1;
        while (e > 0 && x[e] == 1'b0)
            e--;
        m = 64'(x) << (31 - e);
        lg = 64'(e) << 24;
        for (int i = 23; i >= 0; i--)
        begin
            m = (m * m) >> 31;
            if (m >= 64'h1_0000_0000)
            begin
                m = m >> 1;
                lg[i] = 1'b1;
            end
        end
        prod = 96'(lg) * 96'(LN2_Q32);
        return longint'(prod >> 32);
    endfunction

    function automatic drag_result_t predict_drag(logic [31:0] h, logic [31:0] z,
                                                  logic [31:0] fl, logic last);
        drag_result_t r;
        longint       lr, den, num;
        logic [63:0]  nm, dm;
        logic [127:0] q;
        logic [127:0] sq;
        r.last = last;
        if (z >= h)
        begin
            r.drag = '0;
            r.cls = CLS_DRY;
            return r;
        end
        if (z == 0)
        begin
            r.cls = CLS_VISCOUS;
            z = (rough_default != 0) ? rough_default : 32'd1;
        end
        else
            r.cls = CLS_ROUGH;
        lr = log_q24(h) - log_q24(z);
        den = longint'({32'd0, h}) * lr
            + (longint'({32'd0, z}) - longint'({32'd0, h})) * 64'sd16777216;
        num = longint'({48'd0, karman}) * (longint'({32'd0, h}) - longint'({32'd0, z}));
        nm = num < 0 ? 64'(-num) : 64'(num);
        dm = den < 0 ? 64'(-den) : 64'(den);
        if (dm == 0)
            r.drag = DRAG_MAX;
        else
        begin
            q = ({64'd0, nm} << 32) / {64'd0, dm};
            if (q >= 128'h1_0000_0000)
                r.drag = DRAG_MAX;
            else
            begin
                sq = (q * q) >> 24;
                r.drag = (sq > 128'(DRAG_MAX)) ? DRAG_MAX : sq[31:0];
                if (r.drag < fl)
                    r.drag = fl;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        drag_result_t e;
        if (!rst_n)
        begin
            karman <= KARMAN_RESET;
            rough_default <= ROUGH_RESET;
            fail_count = 0;
            expected_drag_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_ROUGH)
                    rough_default <= pwdata;
                else
                    karman <= pwdata[15:0];
            end
            if (in_valid && in_ready)
                expected_drag_q.push_back(predict_drag(depth, rough_len, min_drag, last_node));
            if (out_valid && out_ready)
            begin
                if (expected_drag_q.size() == 0)
                    report_mismatch("unexpected transfer", drag, 0);
                else
                begin
                    e = expected_drag_q.pop_front();
                    if (drag !== e.drag)
                        report_mismatch("drag", drag, e.drag);
                    if (node_class !== e.cls)
                        report_mismatch("node_class", 32'(node_class), 32'(e.cls));
                    if (last_out !== e.last)
                        report_mismatch("last_out", 32'(last_out), 32'(e.last));
                end
            end
        end
    end

endmodule

/* test/tb_log_law_drag_coefficient.sv */
// testbench top: clock, reset, register writes, node stimulus and verdict
`timescale 1ns / 100ps
module tb_log_law_drag_coefficient;
    import lldc_pkg::*;

    localparam int PIPE_LAT  = 66;
    localparam int CYC_LIMIT = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] depth = '0;
    logic [31:0] rough_len = '0;
    logic [31:0] min_drag = '0;
    logic        last_node = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] drag;
    logic [1:0]  node_class;
    logic        last_out;
    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    bit          calm = 1'b0;       // no idling on either side
    bit          hold_off = 1'b0;   // long receiver stall requested
    bit          recv_on = 1'b0;

    always #5 clk = ~clk;

    log_law_drag_coefficient dut (.*);

    lldc_checker u_checker (.*);

    // runaway guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYC_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver: random stall bursts, a long hold-off when asked, none when calm
    initial
    begin
        int n;
        @(posedge rst_n);
        recv_on = 1'b1;
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_ready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_off = 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                n = $urandom_range(1, 9);
                out_ready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // one register write: setup then access
    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'(idx) << 2;
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // offer one node and hold it until the transfer
    task automatic send_node(logic [31:0] h, logic [31:0] z, logic [31:0] fl, logic last);
        int n;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 9);
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
        in_valid <= 1'b1;
        depth <= h;
        rough_len <= z;
        min_drag <= fl;
        last_node <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic idle_sender;
        in_valid <= 1'b0;
    endtask

    // wait for every result, then let the pipeline settle
    task automatic drain;
        idle_sender();
        while (pending != 0)
            @(negedge clk);
        repeat (PIPE_LAT + 4) @(negedge clk);
    endtask

    // random node, mostly wet nodes with depth above roughness
    task automatic send_random_node;
        logic [31:0] h, z, fl;
        int          sel;
        sel = $urandom_range(0, 9);
        h = $urandom();
        if ($urandom_range(0, 2) == 0)
            h = h >> $urandom_range(0, 31);
        case (sel)
            0: z = 0;
            1: z = h + $urandom_range(0, 3);
            2: z = $urandom();
            default: z = (h == 0) ? 0 : $urandom_range(1, h);
        endcase
        if (sel >= 7 && h > 16)
            z = h >> $urandom_range(1, 12);
        case ($urandom_range(0, 3))
            0: fl = $urandom();
            1: fl = 0;
            default: fl = $urandom_range(0, 32'h0010_0000);
        endcase
        send_node(h, z, fl, $urandom_range(0, 1));
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        wait (recv_on);

        // directed: field extremes, dry, viscous, rough, zero denominator
        send_node(32'h0, 32'h0, 32'h0, 1'b0);
        send_node(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_node(32'h0001_0000, 32'h0002_0000, 32'h1234_5678, 1'b0);
        send_node(32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1);
        send_node(32'h0001_0000, 32'h0, 32'h0, 1'b0);
        send_node(32'h2, 32'h1, 32'h0, 1'b0);
        send_node(32'h1, 32'h0, 32'h0, 1'b1);
        send_node(32'hFFFF_FFFF, 32'h1, 32'h0, 1'b0);
        send_node(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h0, 1'b1);
        send_node(32'h000A_0000, 32'h0000_0666, 32'hFFFF_FFFF, 1'b0);
        send_node(32'h000A_0000, 32'h0000_0666, 32'h0, 1'b1);
        send_node(32'h0000_0040, 32'h0, 32'h0, 1'b0);
        drain();

        // viscous node with default roughness at or above depth, zero default
        write_reg(REG_ROUGH, 32'hFFFF_FFFF);
        write_reg(REG_KARMAN, 16'hFFFF);
        send_node(32'h0010_0000, 32'h0, 32'h0, 1'b0);
        send_node(32'h0000_0042, 32'h0, 32'h0, 1'b1);
        send_node(32'h8000_0000, 32'h4000_0000, 32'h0, 1'b0);
        drain();
        write_reg(REG_ROUGH, 32'h0);
        write_reg(REG_KARMAN, 16'h0);
        send_node(32'h0010_0000, 32'h0, 32'h0, 1'b0);
        send_node(32'h0000_0002, 32'h0, 32'h0, 1'b1);
        send_node(32'h0010_0000, 32'h0000_0100, 32'h0000_0001, 1'b0);
        drain();

        // random phases over several register settings
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin write_reg(REG_KARMAN, KARMAN_RESET);
                         write_reg(REG_ROUGH, ROUGH_RESET); end
                1: begin write_reg(REG_KARMAN, $urandom_range(0, 16'hFFFF));
                         write_reg(REG_ROUGH, $urandom()); end
                2: begin write_reg(REG_KARMAN, 16'hFFFF);
                         write_reg(REG_ROUGH, 32'h1); end
                3: begin write_reg(REG_KARMAN, $urandom_range(0, 16'hFFFF));
                         write_reg(REG_ROUGH, $urandom_range(1, 32'h0001_0000)); end
                default: begin write_reg(REG_KARMAN, KARMAN_RESET);
                               write_reg(REG_ROUGH, ROUGH_RESET); end
            endcase
            if (ph == 1)
                hold_off = 1'b1;   // receiver stalls long while nodes keep coming
            if (ph == 4)
                calm = 1'b1;
            for (int i = 0; i < 240; i++)
                send_random_node();
            drain();
        end

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
